FILE: sv/bdev_pkg.sv
// bdev_pkg: shared types and constants for the button debounce event detector
// holds register indexes, reset values, the config bundle and the result beat type
// no dependencies
`timescale 1ns / 1ps

package bdev_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned TIME_W    = 32;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE       = 3'd4;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE   = 16'd15;
    localparam logic [CFG_W-1:0] RST_SHORT_MAX  = 16'd1000;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS = 16'd3000;
    localparam logic [CFG_W-1:0] RST_REPEAT     = 16'd1000;
    localparam logic [CFG_W-1:0] RST_IDLE       = 16'd2000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] short_max_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] repeat_ms;
        logic [CFG_W-1:0] idle_repeat_ms;
    } bdev_cfg_t;

    typedef struct packed {
        logic stable_level;
        logic evt_press;
        logic evt_short;
        logic evt_release;
        logic evt_long;
        logic evt_repeat;
        logic evt_idle;
    } bdev_result_t;

endpackage

FILE: sv/bdev_cfg_regs.sv
// bdev_cfg_regs: the five interval registers behind the plain write port
// depends on bdev_pkg
`timescale 1ns / 1ps

module bdev_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bdev_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdev_pkg::CFG_W-1:0]         cfg_wdata,
    output bdev_pkg::bdev_cfg_t                cfg
);
    import bdev_pkg::*;

    bdev_cfg_t cfg_reg;
    bdev_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEBOUNCE:   cfg_next.debounce_ms    = cfg_wdata;
                REG_SHORT_MAX:  cfg_next.short_max_ms   = cfg_wdata;
                REG_LONG_PRESS: cfg_next.long_press_ms  = cfg_wdata;
                REG_REPEAT:     cfg_next.repeat_ms      = cfg_wdata;
                REG_IDLE:       cfg_next.idle_repeat_ms = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms    <= RST_DEBOUNCE;
            cfg_reg.short_max_ms   <= RST_SHORT_MAX;
            cfg_reg.long_press_ms  <= RST_LONG_PRESS;
            cfg_reg.repeat_ms      <= RST_REPEAT;
            cfg_reg.idle_repeat_ms <= RST_IDLE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/bdev_core.sv
// bdev_core: debounce and event state, updated once per accepted poll
// depends on bdev_pkg; result is combinational from the poll and current state
`timescale 1ns / 1ps

module bdev_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bdev_pkg::bdev_cfg_t            cfg,
    input  logic                           step,
    input  logic                           pin_level,
    input  logic [bdev_pkg::TIME_W-1:0]    now_ms,
    output bdev_pkg::bdev_result_t         result
);
    import bdev_pkg::*;

    logic              filt_reg, filt_next;
    logic              deb_reg, deb_next;
    logic [TIME_W-1:0] dstart_reg, dstart_next;
    logic              settled_reg, settled_next;
    logic              lpend_reg, lpend_next;
    logic              ract_reg, ract_next;
    logic [TIME_W-1:0] pstart_reg, pstart_next;
    logic [TIME_W-1:0] rstart_reg, rstart_next;
    logic [TIME_W-1:0] lstart_reg, lstart_next;

    logic              chg, deb_mid, expire, press, release_e;
    logic              lpend_mid, ract_mid, long_e, rep_e, idle_e;
    logic [TIME_W-1:0] el_deb, el_press, el_long, el_rep, el_idle;

    always_comb begin
        chg     = (pin_level != filt_reg);
        deb_mid = deb_reg | chg;
        // a fresh raw change means zero elapsed settle time
        el_deb  = chg ? '0 : (now_ms - dstart_reg);
        expire  = deb_mid && (el_deb >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms});

        press     = expire && (pin_level != settled_reg) && !pin_level;
        release_e = expire && (pin_level != settled_reg) && pin_level;

        el_press  = now_ms - pstart_reg;
        lpend_mid = press ? 1'b1 : (release_e ? 1'b0 : lpend_reg);
        ract_mid  = press ? 1'b1 : (release_e ? 1'b0 : ract_reg);

        // marks set on this poll give zero elapsed time
        el_long = press ? '0 : el_press;
        el_rep  = press ? '0 : (now_ms - rstart_reg);
        el_idle = release_e ? '0 : (now_ms - lstart_reg);

        long_e = lpend_mid && (el_long >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms});
        rep_e  = ract_mid && (el_rep >= {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_ms});
        idle_e = !ract_mid && (el_idle >= {{(TIME_W-CFG_W){1'b0}}, cfg.idle_repeat_ms});

        filt_next    = pin_level;
        deb_next     = deb_mid && !expire;
        dstart_next  = chg ? now_ms : dstart_reg;
        settled_next = expire ? pin_level : settled_reg;
        lpend_next   = lpend_mid && !long_e;
        ract_next    = ract_mid;
        pstart_next  = press ? now_ms : pstart_reg;
        rstart_next  = (press || rep_e) ? now_ms : rstart_reg;
        lstart_next  = (release_e || idle_e) ? now_ms : lstart_reg;

        result.stable_level = settled_next;
        result.evt_press    = press;
        result.evt_short    = release_e
                              && (el_press <= {{(TIME_W-CFG_W){1'b0}}, cfg.short_max_ms});
        result.evt_release  = release_e;
        result.evt_long     = long_e;
        result.evt_repeat   = rep_e;
        result.evt_idle     = idle_e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg    <= 1'b1;
            deb_reg     <= 1'b0;
            dstart_reg  <= '0;
            settled_reg <= 1'b1;
            lpend_reg   <= 1'b0;
            ract_reg    <= 1'b0;
            pstart_reg  <= '0;
            rstart_reg  <= '0;
            lstart_reg  <= '0;
        end else if (step) begin
            filt_reg    <= filt_next;
            deb_reg     <= deb_next;
            dstart_reg  <= dstart_next;
            settled_reg <= settled_next;
            lpend_reg   <= lpend_next;
            ract_reg    <= ract_next;
            pstart_reg  <= pstart_next;
            rstart_reg  <= rstart_next;
            lstart_reg  <= lstart_next;
        end
    end

endmodule

FILE: sv/bdev_out_stage.sv
// bdev_out_stage: result register between the event logic and the m_ channel
// depends on bdev_pkg
`timescale 1ns / 1ps

module bdev_out_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bdev_pkg::bdev_result_t    in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bdev_pkg::bdev_result_t    out_data
);
    import bdev_pkg::*;

    logic         valid_reg, valid_next;
    bdev_result_t data_reg;

    // a held beat blocks only when it is not being taken this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/button_debounce_event_detector_unit.sv
// button_debounce_event_detector_unit: top level of the button debounce event detector
// depends on bdev_pkg, bdev_cfg_regs, bdev_core, bdev_out_stage
`timescale 1ns / 1ps

// Each s_ beat is one poll of the raw active-low button level with a free-running
// millisecond timestamp, and it yields one m_ beat carrying the debounced level and
// one-poll flags for press, short press, release, long press, repeat and idle. A poll
// is taken every cycle s_ready is high: the debounce and event state updates in the
// cycle the beat is accepted, and a single result register decouples the two channels,
// so s_ready only drops while it holds a beat m_ready does not take. Write the interval
// registers via the cfg_ port only with no poll in flight; the block does not check it.
module button_debounce_event_detector_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bdev_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdev_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_pin_level,
    input  logic [bdev_pkg::TIME_W-1:0]        s_now_ms,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_stable_level,
    output logic                               m_evt_press,
    output logic                               m_evt_short,
    output logic                               m_evt_release,
    output logic                               m_evt_long,
    output logic                               m_evt_repeat,
    output logic                               m_evt_idle
);
    import bdev_pkg::*;

    bdev_cfg_t    cfg;
    bdev_result_t core_result;
    bdev_result_t out_result;
    logic         step;

    assign step = s_valid && s_ready;

    bdev_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bdev_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (step),
        .pin_level (s_pin_level),
        .now_ms    (s_now_ms),
        .result    (core_result)
    );

    bdev_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (core_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_stable_level = out_result.stable_level;
    assign m_evt_press    = out_result.evt_press;
    assign m_evt_short    = out_result.evt_short;
    assign m_evt_release  = out_result.evt_release;
    assign m_evt_long     = out_result.evt_long;
    assign m_evt_repeat   = out_result.evt_repeat;
    assign m_evt_idle     = out_result.evt_idle;

endmodule
